[hdl/touch_coordinate_conditioner_core_defines.svh]
// ----------------------------------------------------------------------------
// Touch coordinate conditioner assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TOUCH_COORDINATE_CONDITIONER_CORE_DEFINES_SVH
`define TOUCH_COORDINATE_CONDITIONER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch coordinate conditioner package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int RAW_W   = 12;
    localparam int PRESS_W = 16;
    localparam int SPLIT_W = 12;
    localparam int BASE_W  = 13;
    localparam int DSR_W   = 8;
    localparam int OFFS_W  = 12;
    localparam int THR_W   = 10;
    localparam int DIV_W   = 13;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 13;

    localparam logic [IDX_W-1:0] REG_X_SPLIT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_BASE_LOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_BASE_HIGH = 3'd2;
    localparam logic [IDX_W-1:0] REG_X_DIVISOR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET    = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_DIVISOR   = 3'd5;
    localparam logic [IDX_W-1:0] REG_MOVE_THRESH = 3'd6;

    localparam logic [SPLIT_W-1:0] RST_X_SPLIT     = 12'd3000;
    localparam logic [BASE_W-1:0]  RST_X_BASE_LOW  = 13'd3870;
    localparam logic [BASE_W-1:0]  RST_X_BASE_HIGH = 13'd3800;
    localparam logic [DSR_W-1:0]   RST_X_DIVISOR   = 8'd15;
    localparam logic [OFFS_W-1:0]  RST_Y_OFFSET    = 12'd360;
    localparam logic [DSR_W-1:0]   RST_Y_DIVISOR   = 8'd11;
    localparam logic [THR_W-1:0]   RST_MOVE_THRESH = 10'd5;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV_X  = 5'b00010,
        ST_DIV_Y  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage
`default_nettype wire

[hdl/touch_coordinate_conditioner_core.sv]
// An item that is not touched goes from idle straight to the finish state, where
// its result is registered onto the output once the output is free; the next item
// can be taken when the block is back in idle. A touched item first takes two
// 13-step passes of the shared divider, X then Y, with a load, a handoff and a
// done, then an update and the finish state, and the output stage as above.
// Synchronous active-low reset restores the register defaults and clears the
// held position and pressure to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "touch_coordinate_conditioner_core_defines.svh"
// ----------------------------------------------------------------------------
// Touch coordinate conditioner
// Calibrates raw touch samples to screen pixels with a movement deadband.
// ----------------------------------------------------------------------------
module touch_coordinate_conditioner_core
    import tcc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // raw_x, raw_y, raw_pressure
    input  wire logic [39:0]          s_tdata,
    // touched
    input  wire logic [0:0]           s_tuser,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // screen_x, screen_y, pressure, zero fill
    output      logic [((($clog2(SCREEN_WIDTH) + $clog2(SCREEN_HEIGHT) + 16) + 7) / 8) * 8 - 1:0]
                                      m_tdata,
    // touch_flag
    output      logic [0:0]           m_tuser
);

    localparam int X_W      = $clog2(SCREEN_WIDTH);
    localparam int Y_W      = $clog2(SCREEN_HEIGHT);
    localparam int OUT_BITS = X_W + Y_W + PRESS_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int XY_W     = (X_W > Y_W) ? X_W : Y_W;
    localparam int CMP_W    = ((XY_W > THR_W) ? XY_W : THR_W) + 1;

    localparam logic [DIV_W-1:0] X_LIM = DIV_W'(SCREEN_WIDTH);
    localparam logic [DIV_W-1:0] Y_LIM = DIV_W'(SCREEN_HEIGHT);
    localparam logic [X_W-1:0]   X_MAX = X_W'(SCREEN_WIDTH - 1);
    localparam logic [Y_W-1:0]   Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

    logic [SPLIT_W-1:0] x_split_reg;
    logic [BASE_W-1:0]  x_base_low_reg;
    logic [BASE_W-1:0]  x_base_high_reg;
    logic [DSR_W-1:0]   x_divisor_reg;
    logic [OFFS_W-1:0]  y_offset_reg;
    logic [DSR_W-1:0]   y_divisor_reg;
    logic [THR_W-1:0]   move_thresh_reg;

    state_t             state_reg, state_next;
    logic               touched_reg;
    logic [RAW_W-1:0]   raw_y_reg;
    logic [PRESS_W-1:0] raw_press_reg;
    logic [X_W-1:0]     nx_reg;
    logic [X_W-1:0]     held_x_reg;
    logic [Y_W-1:0]     held_y_reg;
    logic [PRESS_W-1:0] held_press_reg;
    logic               m_tvalid_reg;
    logic               out_flag_reg;
    logic [X_W-1:0]     out_x_reg;
    logic [Y_W-1:0]     out_y_reg;
    logic [PRESS_W-1:0] out_press_reg;

    div_ctl_t           div_ctl;
    div_stat_t          div_stat;

    logic               s_accept;
    logic               out_load;
    logic [RAW_W-1:0]   in_raw_x;
    logic [BASE_W-1:0]  x_base;
    logic [BASE_W:0]    x_diff;
    logic [RAW_W:0]     y_diff;
    logic [X_W-1:0]     nx_clamped;
    logic [Y_W-1:0]     ny_clamped;
    logic [X_W-1:0]     dist_x;
    logic [Y_W-1:0]     dist_y;
    logic [CMP_W-1:0]   move_dist;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign in_raw_x = s_tdata[RAW_W-1:0];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_split_reg     <= RST_X_SPLIT;
            x_base_low_reg  <= RST_X_BASE_LOW;
            x_base_high_reg <= RST_X_BASE_HIGH;
            x_divisor_reg   <= RST_X_DIVISOR;
            y_offset_reg    <= RST_Y_OFFSET;
            y_divisor_reg   <= RST_Y_DIVISOR;
            move_thresh_reg <= RST_MOVE_THRESH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_X_SPLIT:     x_split_reg     <= cfg_wdata[SPLIT_W-1:0];
                REG_X_BASE_LOW:  x_base_low_reg  <= cfg_wdata[BASE_W-1:0];
                REG_X_BASE_HIGH: x_base_high_reg <= cfg_wdata[BASE_W-1:0];
                REG_X_DIVISOR:   x_divisor_reg   <= cfg_wdata[DSR_W-1:0];
                REG_Y_OFFSET:    y_offset_reg    <= cfg_wdata[OFFS_W-1:0];
                REG_Y_DIVISOR:   y_divisor_reg   <= cfg_wdata[DSR_W-1:0];
                REG_MOVE_THRESH: move_thresh_reg <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Offsets ahead of the divider; a negative difference divides as zero.
    assign x_base = (in_raw_x <= x_split_reg) ? x_base_low_reg : x_base_high_reg;
    assign x_diff = {1'b0, x_base} - {2'b00, in_raw_x};
    assign y_diff = {1'b0, raw_y_reg} - {1'b0, y_offset_reg};

    always_comb begin
        div_ctl.start    = 1'b0;
        div_ctl.dividend = '0;
        div_ctl.divisor  = '0;
        if (state_reg == ST_IDLE) begin
            div_ctl.start    = s_accept && s_tuser[0];
            div_ctl.dividend = x_diff[BASE_W] ? '0 : x_diff[DIV_W-1:0];
            div_ctl.divisor  = (x_divisor_reg == '0) ? DSR_W'(1) : x_divisor_reg;
        end else begin
            div_ctl.start    = (state_reg == ST_DIV_X) && div_stat.done;
            div_ctl.dividend = y_diff[RAW_W] ? '0 : DIV_W'(y_diff[RAW_W-1:0]);
            div_ctl.divisor  = (y_divisor_reg == '0) ? DSR_W'(1) : y_divisor_reg;
        end
    end

    tcc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .stat    (div_stat)
    );

    assign nx_clamped = (div_stat.quotient >= X_LIM) ? X_MAX : div_stat.quotient[X_W-1:0];
    assign ny_clamped = (div_stat.quotient >= Y_LIM) ? Y_MAX : div_stat.quotient[Y_W-1:0];

    assign dist_x = (nx_reg >= held_x_reg) ? (nx_reg - held_x_reg) : (held_x_reg - nx_reg);
    assign dist_y = (ny_clamped >= held_y_reg) ? (ny_clamped - held_y_reg)
                                               : (held_y_reg - ny_clamped);
    assign move_dist = CMP_W'(dist_x) + CMP_W'(dist_y);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_tuser[0] ? ST_DIV_X : ST_FINISH;
                end
            end
            ST_DIV_X: begin
                if (div_stat.done) begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_stat.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_press_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE) begin
                if (move_dist > CMP_W'(move_thresh_reg)) begin
                    held_x_reg <= nx_reg;
                    held_y_reg <= ny_clamped;
                end
                held_press_reg <= raw_press_reg;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            touched_reg   <= s_tuser[0];
            raw_y_reg     <= s_tdata[2*RAW_W-1:RAW_W];
            raw_press_reg <= s_tdata[2*RAW_W+PRESS_W-1:2*RAW_W];
        end
        if ((state_reg == ST_DIV_X) && div_stat.done) begin
            nx_reg <= nx_clamped;
        end
        if (out_load) begin
            out_flag_reg  <= touched_reg;
            out_x_reg     <= held_x_reg;
            out_y_reg     <= held_y_reg;
            out_press_reg <= held_press_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tdata  = OUT_W'({out_press_reg, out_y_reg, out_x_reg});

    `TCC_ASSERT_NEXT(a_untouched_skips, s_accept && !s_tuser[0], state_reg == ST_FINISH,
        "untouched item did not go straight to output")
    `TCC_ASSERT_SAME(a_held_x_range, 1'b1, held_x_reg <= X_MAX, "held X beyond screen")
    `TCC_ASSERT_SAME(a_held_y_range, 1'b1, held_y_reg <= Y_MAX, "held Y beyond screen")
    `TCC_ASSERT_SAME(a_div_active, (state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y),
        div_stat.busy || div_stat.done, "divider idle during a divide state")

endmodule
`default_nettype wire

[hdl/tcc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch coordinate conditioner divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcc_div
    import tcc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire div_ctl_t  ctl,
    output div_stat_t      stat
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = ctl.dividend;
            dsr_next  = ctl.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule
`default_nettype wire

[test/touch_coordinate_conditioner_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch coordinate conditioner testbench
// Streams touch samples through the block under several register settings and
// checks every item on the result stream against an in-bench predictor of the
// calibration, clamping and movement deadband.
// ----------------------------------------------------------------------------
module touch_coordinate_conditioner_core_test;
    import tcc_pkg::*;

    localparam int SCREEN_W = 240;
    localparam int SCREEN_H = 320;
    localparam int X_W      = $clog2(SCREEN_W);
    localparam int Y_W      = $clog2(SCREEN_H);
    localparam int M_W      = (((X_W + Y_W + PRESS_W) + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        bit               touch_flag;
        bit [X_W-1:0]     screen_x;
        bit [Y_W-1:0]     screen_y;
        bit [PRESS_W-1:0] pressure;
    } touch_report_t;

    class touch_scoreboard;
        bit [SPLIT_W-1:0] x_split;
        bit [BASE_W-1:0]  x_base_low;
        bit [BASE_W-1:0]  x_base_high;
        bit [DSR_W-1:0]   x_divisor;
        bit [OFFS_W-1:0]  y_offset;
        bit [DSR_W-1:0]   y_divisor;
        bit [THR_W-1:0]   move_thresh;
        bit [X_W-1:0]     held_x;
        bit [Y_W-1:0]     held_y;
        bit [PRESS_W-1:0] held_press;
        touch_report_t    pending_reports[$];
        int               mismatches;

        function new();
            x_split     = RST_X_SPLIT;
            x_base_low  = RST_X_BASE_LOW;
            x_base_high = RST_X_BASE_HIGH;
            x_divisor   = RST_X_DIVISOR;
            y_offset    = RST_Y_OFFSET;
            y_divisor   = RST_Y_DIVISOR;
            move_thresh = RST_MOVE_THRESH;
            held_x      = '0;
            held_y      = '0;
            held_press  = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(bit [IDX_W-1:0] idx, bit [CFG_W-1:0] value);
            case (idx)
                REG_X_SPLIT:     x_split     = value[SPLIT_W-1:0];
                REG_X_BASE_LOW:  x_base_low  = value[BASE_W-1:0];
                REG_X_BASE_HIGH: x_base_high = value[BASE_W-1:0];
                REG_X_DIVISOR:   x_divisor   = value[DSR_W-1:0];
                REG_Y_OFFSET:    y_offset    = value[OFFS_W-1:0];
                REG_Y_DIVISOR:   y_divisor   = value[DSR_W-1:0];
                REG_MOVE_THRESH: move_thresh = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Offset, divide and clamp one axis; a zero divisor counts as one.
        function int unsigned scale_to_screen(int unsigned hi, int unsigned lo,
                                              int unsigned div, int unsigned size);
            int unsigned q;
            if (hi <= lo) return 0;
            if (div == 0) div = 1;
            q = (hi - lo) / div;
            if (q >= size) q = size - 1;
            return q;
        endfunction

        function void note_sample(bit touched, bit [RAW_W-1:0] raw_x,
                                  bit [RAW_W-1:0] raw_y, bit [PRESS_W-1:0] raw_press);
            int unsigned   base;
            int unsigned   nx;
            int unsigned   ny;
            int unsigned   move_dist;
            touch_report_t rep;
            if (touched) begin
                base = (raw_x <= x_split) ? x_base_low : x_base_high;
                nx = scale_to_screen(base, raw_x, x_divisor, SCREEN_W);
                ny = scale_to_screen(raw_y, y_offset, y_divisor, SCREEN_H);
                move_dist = ((nx > held_x) ? nx - held_x : held_x - nx)
                          + ((ny > held_y) ? ny - held_y : held_y - ny);
                if (move_dist > move_thresh) begin
                    held_x = X_W'(nx);
                    held_y = Y_W'(ny);
                end
                held_press = raw_press;
            end
            rep.touch_flag = touched;
            rep.screen_x   = held_x;
            rep.screen_y   = held_y;
            rep.pressure   = held_press;
            pending_reports.push_back(rep);
        endfunction

        function void check_report(touch_report_t got);
            touch_report_t want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected item: flag %0d x %0d y %0d pressure %0d",
                             got.touch_flag, got.screen_x, got.screen_y, got.pressure);
                return;
            end
            want = pending_reports.pop_front();
            if (got.touch_flag != want.touch_flag || got.screen_x != want.screen_x ||
                got.screen_y != want.screen_y || got.pressure != want.pressure) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Item differs: expected flag %0d x %0d y %0d pressure %0d, %s",
                             want.touch_flag, want.screen_x, want.screen_y, want.pressure,
                             $sformatf("got flag %0d x %0d y %0d pressure %0d",
                                       got.touch_flag, got.screen_x, got.screen_y,
                                       got.pressure));
            end
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    // raw_x, raw_y, raw_pressure
    logic [39:0]        s_tdata   = '0;
    // touched
    logic [0:0]         s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    // screen_x, screen_y, pressure, zero fill
    logic [M_W-1:0]     m_tdata;
    // touch_flag
    logic [0:0]         m_tuser;

    touch_scoreboard board = new();
    bit no_gaps      = 1'b0;
    bit hold_request = 1'b0;
    int cur_x        = 2000;
    int cur_y        = 2000;

    touch_coordinate_conditioner_core #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge aclk) begin
        touch_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.touch_flag = m_tuser[0];
            got.screen_x   = m_tdata[X_W-1:0];
            got.screen_y   = m_tdata[X_W+Y_W-1:X_W];
            got.pressure   = m_tdata[X_W+Y_W+PRESS_W-1:X_W+Y_W];
            board.check_report(got);
        end
    end

    // Result side: a random stall before each item (none when no_gaps is set), or one long hold-off when asked.
    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                wait_cycles = no_gaps ? 0 : $urandom_range(0, 5);
                if (wait_cycles > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
            end
        end
    end

    task automatic send_sample(bit touched, bit [RAW_W-1:0] raw_x,
                               bit [RAW_W-1:0] raw_y, bit [PRESS_W-1:0] raw_press);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= touched;
        s_tdata  <= {raw_press, raw_y, raw_x};
        do @(posedge aclk); while (!s_tready);
        board.note_sample(touched, raw_x, raw_y, raw_press);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_reports.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(bit [IDX_W-1:0] idx, bit [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.write_reg(idx, value);
    endtask

    task automatic write_settings(bit [CFG_W-1:0] split, bit [CFG_W-1:0] base_lo,
                                  bit [CFG_W-1:0] base_hi, bit [CFG_W-1:0] x_div,
                                  bit [CFG_W-1:0] y_offs, bit [CFG_W-1:0] y_div,
                                  bit [CFG_W-1:0] thresh);
        write_reg(REG_X_SPLIT, split);
        write_reg(REG_X_BASE_LOW, base_lo);
        write_reg(REG_X_BASE_HIGH, base_hi);
        write_reg(REG_X_DIVISOR, x_div);
        write_reg(REG_Y_OFFSET, y_offs);
        write_reg(REG_Y_DIVISOR, y_div);
        write_reg(REG_MOVE_THRESH, thresh);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bit [CFG_W-1:0] rand_divisor();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 20);
    endfunction

    // Mostly drags: small moves around the last point, so the deadband decides.
    task automatic run_drags(int count);
        int pick;
        int step;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_sample(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 65535));
            end else begin
                if (pick < 25) begin
                    cur_x = $urandom_range(0, 4095);
                    cur_y = $urandom_range(0, 4095);
                end else begin
                    step = $urandom_range(0, 4 * (board.x_divisor + 1));
                    cur_x = $urandom_range(0, 1) ? cur_x + step : cur_x - step;
                    step = $urandom_range(0, 4 * (board.y_divisor + 1));
                    cur_y = $urandom_range(0, 1) ? cur_y + step : cur_y - step;
                    cur_x = (cur_x < 0) ? 0 : (cur_x > 4095) ? 4095 : cur_x;
                    cur_y = (cur_y < 0) ? 0 : (cur_y > 4095) ? 4095 : cur_y;
                end
                send_sample(1'b1, cur_x, cur_y, $urandom_range(0, 65535));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(1'b0, 12'd0, 12'd0, 16'd0);
        send_sample(1'b1, 12'd0, 12'd4095, 16'hFFFF);
        send_sample(1'b1, 12'd4095, 12'd0, 16'h0000);
        send_sample(1'b1, 12'hAAA, 12'h555, 16'hAAAA);
        send_sample(1'b1, 12'h555, 12'hAAA, 16'h5555);
        send_sample(1'b1, 12'd3000, 12'd1460, 16'h1234);
        send_sample(1'b1, 12'd3001, 12'd1460, 16'h1235);
        send_sample(1'b1, 12'd3000, 12'd1515, 16'h1236);
        send_sample(1'b1, 12'd3000, 12'd1526, 16'h1237);
        send_sample(1'b0, 12'd4095, 12'd4095, 16'hFFFF);
        send_sample(1'b1, 12'd3870, 12'd360, 16'h0F0F);
        send_sample(1'b1, 12'd2999, 12'd371, 16'hF0F0);
        wait_drained();

        write_settings(0, 0, 0, 0, 0, 0, 0);
        run_drags(90);
        wait_drained();

        write_settings(4095, 8191, 8191, 255, 4095, 255, 1023);
        run_drags(90);
        wait_drained();

        write_settings(2048, 300, 4000, 1, 100, 1, 1);
        hold_request = 1'b1;
        run_drags(110);
        wait_drained();

        no_gaps = 1'b1;
        write_settings(RST_X_SPLIT, RST_X_BASE_LOW, RST_X_BASE_HIGH, RST_X_DIVISOR,
                       RST_Y_OFFSET, RST_Y_DIVISOR, RST_MOVE_THRESH);
        run_drags(110);
        wait_drained();
        no_gaps = 1'b0;

        repeat (5) begin
            write_settings($urandom_range(0, 8191), $urandom_range(0, 8191),
                           $urandom_range(0, 8191), rand_divisor(),
                           $urandom_range(0, 8191), rand_divisor(),
                           $urandom_range(0, 1) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 12));
            run_drags(90);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
